[rtl/brb_pkg.sv]
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Field widths, request codes and the command and status bundles shared by
// the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int ACTION_W = 2;
   localparam int DATA_W   = 8;
   localparam int AMT_W    = 7;
   localparam int LEVEL_W  = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE = 2'd0,
      ACT_PEEK  = 2'd1,
      ACT_READ  = 2'd2
   } action_type;

   typedef struct packed {
      logic do_write;
      logic do_refuse;
      logic do_ack;
      logic start_peek;
      logic start_run;
      logic emit_peek;
      logic emit_run;
   } brb_cmd_type;

   typedef struct packed {
      logic wr_ok;
      logic peek_ok;
      logic run_ok;
      logic amount_zero;
      logic out_free;
      logic run_last;
   } brb_stat_type;

endpackage

[rtl/brb_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one request beat into the ring buffer.
// ----------------------------------------------------------------------------
interface brb_req_if;
   logic                         valid;
   logic                         ready;
   logic [brb_pkg::ACTION_W-1:0] action;
   logic [brb_pkg::DATA_W-1:0]   write_data;
   logic [brb_pkg::AMT_W-1:0]    amount;

   modport source (output valid, output action, output write_data, output amount,
                   input ready);
   modport sink   (input valid, input action, input write_data, input amount,
                   output ready);
endinterface

[rtl/brb_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result beat out of the ring buffer.
// ----------------------------------------------------------------------------
interface brb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [brb_pkg::DATA_W-1:0]  data_out;
   logic                        ok;
   logic                        last;
   logic [brb_pkg::LEVEL_W-1:0] level;
   logic                        full_res;

   modport source (output valid, output data_out, output ok, output last,
                   output level, output full_res, input ready);
   modport sink   (input valid, input data_out, input ok, input last,
                   input level, input full_res, output ready);
endinterface

[rtl/brb_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/brb_ctrl.sv]
// ----------------------------------------------------------------------------
// Ring buffer controller
// Accepts requests, sequences peeks and read runs and drives the datapath.
// ----------------------------------------------------------------------------
module brb_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [brb_pkg::ACTION_W-1:0] req_action,
   output logic                         req_ready,
   input  brb_pkg::brb_stat_type        stat,
   output brb_pkg::brb_cmd_type         cmd
);
   import brb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PEEK,
      ST_RUN
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   logic       accept;
   action_type action;

   assign action    = action_type'(req_action);
   assign req_ready = (state_ff == ST_IDLE) && stat.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (action)
                  ACT_WRITE: begin
                     cmd.do_write  = stat.wr_ok;
                     cmd.do_refuse = !stat.wr_ok;
                  end
                  ACT_PEEK: begin
                     if (stat.peek_ok) begin
                        cmd.start_peek = 1'b1;
                        state_in       = ST_PEEK;
                     end else begin
                        cmd.do_refuse = 1'b1;
                     end
                  end
                  ACT_READ: begin
                     if (!stat.run_ok) begin
                        cmd.do_refuse = 1'b1;
                     end else if (stat.amount_zero) begin
                        cmd.do_ack = 1'b1;
                     end else begin
                        cmd.start_run = 1'b1;
                        state_in      = ST_RUN;
                     end
                  end
                  default: begin
                     cmd.do_refuse = 1'b1;
                  end
               endcase
            end
         end
         ST_PEEK: begin
            if (stat.out_free) begin
               cmd.emit_peek = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (stat.out_free) begin
               cmd.emit_run = 1'b1;
               if (stat.run_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/brb_dp.sv]
// ----------------------------------------------------------------------------
// Ring buffer datapath
// Holds the ring memory, the read and write pointers, the run counter and
// the result register, and reports the checks the controller needs.
// ----------------------------------------------------------------------------
module brb_dp #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [brb_pkg::DATA_W-1:0]   req_write_data,
   input  logic [brb_pkg::AMT_W-1:0]    req_amount,
   input  brb_pkg::brb_cmd_type         cmd,
   output brb_pkg::brb_stat_type        stat,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [brb_pkg::DATA_W-1:0]   rsp_data_out,
   output logic                         rsp_ok,
   output logic                         rsp_last,
   output logic [brb_pkg::LEVEL_W-1:0]  rsp_level,
   output logic                         rsp_full_res
);
   import brb_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PTR_W  = ADDR_W + 1;
   localparam int CMP_W  = (PTR_W > AMT_W) ? PTR_W : AMT_W;
   localparam logic [PTR_W-1:0] DEPTH_PTR = PTR_W'(DEPTH);

   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [AMT_W-1:0]   run_left_ff, run_left_in;
   logic [PTR_W-1:0]   fill, fill_next;
   logic               load;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0]  ram_rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  data_out_ff, data_out_in;
   logic               ok_ff, ok_in;
   logic               last_ff, last_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               full_ff, full_in;

   assign fill = wr_ptr_ff - rd_ptr_ff;

   assign stat.wr_ok       = fill != DEPTH_PTR;
   assign stat.peek_ok     = CMP_W'(req_amount) < CMP_W'(fill);
   assign stat.run_ok      = CMP_W'(req_amount) <= CMP_W'(fill);
   assign stat.amount_zero = req_amount == '0;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;
   assign stat.run_last    = run_left_ff == AMT_W'(1);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(cmd.do_write);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(cmd.emit_run);
   assign fill_next = wr_ptr_in - rd_ptr_in;

   always_comb begin
      run_left_in = run_left_ff;
      if (cmd.start_run) begin
         run_left_in = req_amount;
      end else if (cmd.emit_run) begin
         run_left_in = run_left_ff - AMT_W'(1);
      end
   end

   assign ram_rd_en = cmd.start_peek || cmd.start_run || (cmd.emit_run && !stat.run_last);

   always_comb begin
      if (cmd.start_peek) begin
         ram_rd_addr = rd_ptr_ff[ADDR_W-1:0] + ADDR_W'(req_amount);
      end else begin
         ram_rd_addr = rd_ptr_in[ADDR_W-1:0];
      end
   end

   brb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.do_write),
      .wr_addr (wr_ptr_ff[ADDR_W-1:0]),
      .wr_data (req_write_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign load = cmd.do_write || cmd.do_refuse || cmd.do_ack || cmd.emit_peek || cmd.emit_run;

   always_comb begin
      data_out_in  = data_out_ff;
      ok_in        = ok_ff;
      last_in      = last_ff;
      level_in     = level_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         data_out_in  = (cmd.emit_peek || cmd.emit_run) ? ram_rd_data : '0;
         ok_in        = !cmd.do_refuse;
         last_in      = cmd.emit_run ? stat.run_last : 1'b1;
         level_in     = LEVEL_W'(fill_next);
         full_in      = fill_next == DEPTH_PTR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         run_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         run_left_ff  <= run_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_out_ff <= data_out_in;
      ok_ff       <= ok_in;
      last_ff     <= last_in;
      level_ff    <= level_in;
      full_ff     <= full_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = data_out_ff;
   assign rsp_ok       = ok_ff;
   assign rsp_last     = last_ff;
   assign rsp_level    = level_ff;
   assign rsp_full_res = full_ff;

endmodule

[rtl/byte_ring_buffer_with_peek.sv]
// ----------------------------------------------------------------------------
// Byte ring buffer with peek
// A byte FIFO of DEPTH entries (a power of two) with write, peek and read-run
// requests on the req_chan channel and one result beat per byte on rsp_chan.
//
// Every request produces at least one result beat carrying success, fill level
// and full. Writes and refused requests have registered results, so they can
// be accepted back to back. A peek reads the ring memory, whose read data is
// registered, and loads the byte once the result register is free. A read run
// of N bytes reads its first byte, then emits one byte per cycle while the
// receiver takes the beats, with the last beat marked; no new request is taken
// during the run. The result register decouples the two sides: a new request
// is accepted while a finished beat is being taken in the same cycle. When the
// receiver stalls, the pending beat holds and the block waits without losing
// data. Reset empties the buffer and drops any pending beat; the ring memory
// itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module byte_ring_buffer_with_peek #(
   parameter int DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   brb_req_if.sink   req_chan,
   brb_rsp_if.source rsp_chan
);
   import brb_pkg::*;

   brb_cmd_type  cmd;
   brb_stat_type stat;

   brb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   brb_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_write_data (req_chan.write_data),
      .req_amount     (req_chan.amount),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_data_out   (rsp_chan.data_out),
      .rsp_ok         (rsp_chan.ok),
      .rsp_last       (rsp_chan.last),
      .rsp_level      (rsp_chan.level),
      .rsp_full_res   (rsp_chan.full_res)
   );

endmodule
